@@ src/sbsm_pkg.sv @@
// Shared types, codes and reset values for the serial bank switch mapper.
package sbsm_pkg;

  // Bus event kinds carried on the input tuser field.
  typedef enum logic [2:0] {
    OP_CPU_READ    = 3'd0,
    OP_CPU_WRITE   = 3'd1,
    OP_VIDEO_READ  = 3'd2,
    OP_VIDEO_WRITE = 3'd3,
    OP_TICK        = 3'd4
  } sbsm_op_e;

  // Target memory codes of a result word.
  typedef enum logic [2:0] {
    TGT_OPEN = 3'd0,
    TGT_ZERO = 3'd1,
    TGT_PROM = 3'd2,
    TGT_SRAM = 3'd3,
    TGT_CROM = 3'd4,
    TGT_CRAM = 3'd5,
    TGT_NTBL = 3'd6,
    TGT_NONE = 3'd7
  } sbsm_target_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_BOARD_VARIANT = 2'd0,
    REG_CHR_ROM       = 2'd1,
    REG_CHR_RAM       = 2'd2,
    REG_UNUSED        = 2'd3
  } sbsm_reg_e;

  // Board variants with their own bank extensions.
  localparam logic [2:0] VAR_RAM_DISABLE = 3'd1;
  localparam logic [2:0] VAR_RAM_BIT3    = 3'd2;
  localparam logic [2:0] VAR_RAM_BITS32  = 3'd3;
  localparam logic [2:0] VAR_PRG_BIT4    = 3'd4;

  // Serial load: five bits make one register write, two ticks of holdoff.
  localparam logic [2:0] SHIFT_BITS    = 3'd5;
  localparam logic [1:0] HOLDOFF_TICKS = 2'd2;

  // Mirroring codes.
  localparam logic [1:0] MIR_SINGLE_LOW  = 2'd0;
  localparam logic [1:0] MIR_SINGLE_HIGH = 2'd1;
  localparam logic [1:0] MIR_VERTICAL    = 2'd2;
  localparam logic [1:0] MIR_HORIZONTAL  = 2'd3;

  typedef struct packed {
    logic [2:0] board_variant;
    logic       chr_rom_present;
    logic       chr_ram_present;
  } sbsm_cfg_t;

  typedef struct packed {
    logic [1:0] write_holdoff;
    logic [2:0] shift_count;
    logic [4:0] shift_value;
    logic [1:0] mirroring;
    logic       prg_fixed_half;
    logic       prg_16k_mode;
    logic       chr_4k_mode;
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic [3:0] prg_bank;
    logic       save_ram_off;
  } sbsm_state_t;

  typedef struct packed {
    sbsm_target_e target;
    logic [18:0]  mapped_address;
    logic         write_strobe;
  } sbsm_result_t;

  localparam sbsm_state_t STATE_RESET = '{
    write_holdoff:  2'd0,
    shift_count:    3'd0,
    shift_value:    5'd0,
    mirroring:      2'd0,
    prg_fixed_half: 1'b1,
    prg_16k_mode:   1'b1,
    chr_4k_mode:    1'b0,
    chr_bank_low:   5'd0,
    chr_bank_high:  5'd1,
    prg_bank:       4'd0,
    save_ram_off:   1'b0
  };

endpackage

@@ src/serial_bank_switch_mapper.sv @@
// Top level of the serial bank switch mapper: stream ports, APB registers and result register.
//
// Channel   Direction  Contents
// s_axis    in         bus event word: address, write data; kind in tuser
// m_axis    out        result word: mapped address; target and strobe in tuser
// apb       in/out     board variant, character ROM and character RAM fitted
//
// One word is accepted per cycle; its result appears in the output register on
// the next cycle. The decode is a single pass of combinational logic between the
// mapper state and the result register.
// Reset is asynchronous and active low and puts the mapper in its power-on banking.
// When the output is stalled, a new word is taken only as the held result leaves.
module serial_bank_switch_mapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] address, [23:16] write_data
  input  logic [2:0]  s_axis_tuser,   // [2:0] operation
  // Result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [18:0] mapped_address, [23:19] zero
  output logic [3:0]  m_axis_tuser,   // [2:0] target, [3] write_strobe
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sbsm_pkg::*;

  sbsm_cfg_t    cfg_q;
  sbsm_state_t  state_q;
  sbsm_state_t  state_d;
  sbsm_result_t res_d;
  sbsm_result_t res_q;
  logic         out_valid_q;
  logic         in_accept;
  logic         cfg_write;
  sbsm_reg_e    reg_sel;

  assign pready    = 1'b1;
  assign reg_sel   = sbsm_reg_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{board_variant: 3'd0, chr_rom_present: 1'b1, chr_ram_present: 1'b0};
    end else if (cfg_write) begin
      case (reg_sel)
        REG_BOARD_VARIANT: cfg_q.board_variant   <= pwdata[2:0];
        REG_CHR_ROM:       cfg_q.chr_rom_present <= pwdata[0];
        REG_CHR_RAM:       cfg_q.chr_ram_present <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_sel)
      REG_BOARD_VARIANT: prdata = {29'd0, cfg_q.board_variant};
      REG_CHR_ROM:       prdata = {31'd0, cfg_q.chr_rom_present};
      REG_CHR_RAM:       prdata = {31'd0, cfg_q.chr_ram_present};
      default:           prdata = 32'd0;
    endcase
  end

  // Decode of the incoming word against the current mapper state.
  sbsm_decode u_decode (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .op_i    (s_axis_tuser),
    .addr_i  (s_axis_tdata[15:0]),
    .data_i  (s_axis_tdata[23:16]),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // A word enters when the result register is empty or being emptied.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Mapper state and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q <= state_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, res_q.mapped_address};
  assign m_axis_tuser  = {res_q.write_strobe, res_q.target};

endmodule

@@ src/sbsm_decode.sv @@
// Access decode, address translation and serial register load for one bus event.
module sbsm_decode (
  input  sbsm_pkg::sbsm_cfg_t    cfg_i,
  input  sbsm_pkg::sbsm_state_t  state_i,
  input  logic [2:0]             op_i,
  input  logic [15:0]            addr_i,
  input  logic [7:0]             data_i,
  output sbsm_pkg::sbsm_state_t  state_o,
  output sbsm_pkg::sbsm_result_t res_o
);
  import sbsm_pkg::*;

  logic        sram_window;
  logic        sram_blocked;
  logic        rom_half;
  logic [4:0]  rom_bank;
  logic [1:0]  sram_bank;
  logic        chr_half;
  logic [4:0]  chr_bank;
  logic [18:0] rom_addr;
  logic [18:0] sram_addr;
  logic [18:0] chr_addr;
  logic [18:0] nt_addr;
  logic [4:0]  shift_next;
  logic [2:0]  count_next;

  // Program ROM bank: 32K mode pairs banks, 16K mode fixes one half.
  always_comb begin
    rom_half = addr_i[14];
    rom_bank = {1'b0, state_i.prg_bank[3:1], rom_half};
    if (state_i.prg_16k_mode) begin
      rom_bank = rom_half ? 5'h0f : 5'h00;
      if (rom_half != state_i.prg_fixed_half) begin
        rom_bank = {1'b0, state_i.prg_bank};
      end
    end
    if (cfg_i.board_variant == VAR_PRG_BIT4) begin
      rom_bank[4] = state_i.chr_bank_low[4];
    end
    rom_addr = {rom_bank, addr_i[13:0]};
  end

  // Save RAM bank from the low character bank on the larger boards.
  always_comb begin
    sram_bank = 2'd0;
    if (cfg_i.board_variant == VAR_RAM_BIT3) begin
      sram_bank = {1'b0, state_i.chr_bank_low[3]};
    end
    if (cfg_i.board_variant == VAR_RAM_BITS32 || cfg_i.board_variant == VAR_PRG_BIT4) begin
      sram_bank = state_i.chr_bank_low[3:2];
    end
    sram_addr    = {4'd0, sram_bank, addr_i[12:0]};
    sram_window  = (addr_i[15:13] == 3'b011);
    sram_blocked = (cfg_i.board_variant == VAR_RAM_DISABLE) && state_i.chr_bank_low[4];
  end

  // Character bank: 4K mode picks a register per half, 8K mode pairs banks.
  always_comb begin
    chr_half = addr_i[12];
    chr_bank = chr_half ? state_i.chr_bank_high : state_i.chr_bank_low;
    if (!state_i.chr_4k_mode) begin
      chr_bank = {state_i.chr_bank_low[4:1], chr_half};
    end
    chr_addr = {2'd0, chr_bank, addr_i[11:0]};
  end

  // Nametable mirroring selects address bit 10 of the internal RAM.
  always_comb begin
    case (state_i.mirroring)
      MIR_SINGLE_LOW:  nt_addr = {8'd0, 1'b0, addr_i[9:0]};
      MIR_SINGLE_HIGH: nt_addr = {8'd0, 1'b1, addr_i[9:0]};
      MIR_VERTICAL:    nt_addr = {8'd0, addr_i[10], addr_i[9:0]};
      MIR_HORIZONTAL:  nt_addr = {8'd0, addr_i[11], addr_i[9:0]};
      default:         nt_addr = {8'd0, 1'b0, addr_i[9:0]};
    endcase
  end

  // Event decode and state update.
  always_comb begin
    state_o    = state_i;
    res_o      = '{target: TGT_NONE, mapped_address: 19'd0, write_strobe: 1'b0};
    shift_next = {data_i[0], state_i.shift_value[4:1]};
    count_next = state_i.shift_count + 3'd1;
    case (sbsm_op_e'(op_i))
      OP_CPU_READ: begin
        if (sram_window) begin
          if (sram_blocked) begin
            res_o.target = TGT_OPEN;
          end else if (state_i.save_ram_off) begin
            res_o.target = TGT_ZERO;
          end else begin
            res_o.target         = TGT_SRAM;
            res_o.mapped_address = sram_addr;
          end
        end else if (addr_i[15]) begin
          res_o.target         = TGT_PROM;
          res_o.mapped_address = rom_addr;
        end else begin
          res_o.target = TGT_OPEN;
        end
      end
      OP_CPU_WRITE: begin
        if (sram_window) begin
          if (!sram_blocked && !state_i.save_ram_off) begin
            res_o.target         = TGT_SRAM;
            res_o.mapped_address = sram_addr;
            res_o.write_strobe   = 1'b1;
          end
        end else if (addr_i[15] && state_i.write_holdoff == 2'd0) begin
          // Serial register load; a set bit 7 restarts the sequence.
          state_o.write_holdoff = HOLDOFF_TICKS;
          if (data_i[7]) begin
            state_o.shift_count    = 3'd0;
            state_o.prg_16k_mode   = 1'b1;
            state_o.prg_fixed_half = 1'b1;
          end else begin
            state_o.shift_value = shift_next;
            state_o.shift_count = count_next;
            if (count_next >= SHIFT_BITS) begin
              state_o.shift_count = 3'd0;
              case (addr_i[14:13])
                2'd0: begin
                  state_o.mirroring      = shift_next[1:0];
                  state_o.prg_fixed_half = shift_next[2];
                  state_o.prg_16k_mode   = shift_next[3];
                  state_o.chr_4k_mode    = shift_next[4];
                end
                2'd1: state_o.chr_bank_low  = shift_next;
                2'd2: state_o.chr_bank_high = shift_next;
                default: begin
                  state_o.prg_bank     = shift_next[3:0];
                  state_o.save_ram_off = shift_next[4];
                end
              endcase
            end
          end
        end
      end
      OP_VIDEO_READ: begin
        if (addr_i[13]) begin
          res_o.target         = TGT_NTBL;
          res_o.mapped_address = nt_addr;
        end else if (cfg_i.chr_rom_present) begin
          res_o.target         = TGT_CROM;
          res_o.mapped_address = chr_addr;
        end else if (cfg_i.chr_ram_present) begin
          res_o.target         = TGT_CRAM;
          res_o.mapped_address = chr_addr;
        end else begin
          res_o.target = TGT_ZERO;
        end
      end
      OP_VIDEO_WRITE: begin
        if (addr_i[13]) begin
          res_o.target         = TGT_NTBL;
          res_o.mapped_address = nt_addr;
          res_o.write_strobe   = 1'b1;
        end else if (cfg_i.chr_ram_present) begin
          res_o.target         = TGT_CRAM;
          res_o.mapped_address = chr_addr;
          res_o.write_strobe   = 1'b1;
        end
      end
      OP_TICK: begin
        if (state_i.write_holdoff != 2'd0) begin
          state_o.write_holdoff = state_i.write_holdoff - 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ tb/sbsm_access_checker.sv @@
// Checker for the serial bank switch mapper: predicts each result word and compares it.
`timescale 1ns / 1ps

module sbsm_access_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [23:0] s_tdata_i,    // [15:0] address, [23:16] write_data
  input  logic [2:0]  s_tuser_i,    // [2:0] operation
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,    // [18:0] mapped_address, [23:19] zero
  input  logic [3:0]  m_tuser_i,    // [2:0] target, [3] write_strobe
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);
  import sbsm_pkg::*;

  // CPU address bits 15:13 that select the save RAM window.
  localparam logic [2:0] SAVE_RAM_WINDOW = 3'b011;

  // Serial register selected by CPU address bits 14:13.
  localparam logic [1:0] SEL_CONTROL  = 2'd0;
  localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
  localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
  localparam logic [1:0] SEL_PRG      = 2'd3;

  sbsm_state_t  mapper;
  sbsm_cfg_t    board;
  sbsm_result_t expected_maps[$];
  int unsigned  mismatch_total;

  // Program ROM: 16 KiB banks, one half fixed in 16 KiB mode.
  function automatic logic [18:0] prog_rom_offset(logic [15:0] a);
    logic       half;
    logic [4:0] bank;
    half = a[14];
    bank = {1'b0, mapper.prg_bank[3:1], half};
    if (mapper.prg_16k_mode) begin
      bank = half ? 5'h0f : 5'h00;
      if (half != mapper.prg_fixed_half) bank = {1'b0, mapper.prg_bank};
    end
    if (board.board_variant == VAR_PRG_BIT4) bank = {mapper.chr_bank_low[4], bank[3:0]};
    return {bank, a[13:0]};
  endfunction

  // Save RAM: 8 KiB banks, bank bits borrowed from the low character bank.
  function automatic logic [18:0] save_ram_offset(logic [15:0] a);
    logic [1:0] bank;
    bank = 2'd0;
    if (board.board_variant == VAR_RAM_BIT3) bank = {1'b0, mapper.chr_bank_low[3]};
    if (board.board_variant == VAR_RAM_BITS32 || board.board_variant == VAR_PRG_BIT4)
      bank = mapper.chr_bank_low[3:2];
    return {4'd0, bank, a[12:0]};
  endfunction

  // Pattern memory: two 4 KiB banks, or one 8 KiB pair.
  function automatic logic [18:0] pattern_offset(logic [13:0] v);
    logic [4:0] bank;
    bank = v[12] ? mapper.chr_bank_high : mapper.chr_bank_low;
    if (!mapper.chr_4k_mode) bank = {mapper.chr_bank_low[4:1], v[12]};
    return {2'd0, bank, v[11:0]};
  endfunction

  // Nametable RAM: 2 KiB, the page chosen by mirroring.
  function automatic logic [18:0] nametable_offset(logic [13:0] v);
    logic page;
    case (mapper.mirroring)
      MIR_SINGLE_LOW:  page = 1'b0;
      MIR_SINGLE_HIGH: page = 1'b1;
      MIR_VERTICAL:    page = v[10];
      default:         page = v[11];
    endcase
    return {8'd0, page, v[9:0]};
  endfunction

  function automatic logic save_ram_disabled();
    return board.board_variant == VAR_RAM_DISABLE && mapper.chr_bank_low[4];
  endfunction

  // One bit of the serial load, or a reset of the shift register.
  function automatic void load_serial_bit(logic [15:0] a, logic [7:0] d);
    if (mapper.write_holdoff != 2'd0) return;
    mapper.write_holdoff = HOLDOFF_TICKS;
    if (d[7]) begin
      mapper.shift_count    = 3'd0;
      mapper.prg_16k_mode   = 1'b1;
      mapper.prg_fixed_half = 1'b1;
      return;
    end
    mapper.shift_value = {d[0], mapper.shift_value[4:1]};
    mapper.shift_count = mapper.shift_count + 3'd1;
    if (mapper.shift_count < SHIFT_BITS) return;
    mapper.shift_count = 3'd0;
    case (a[14:13])
      SEL_CONTROL: begin
        mapper.mirroring      = mapper.shift_value[1:0];
        mapper.prg_fixed_half = mapper.shift_value[2];
        mapper.prg_16k_mode   = mapper.shift_value[3];
        mapper.chr_4k_mode    = mapper.shift_value[4];
      end
      SEL_CHR_LOW:  mapper.chr_bank_low  = mapper.shift_value;
      SEL_CHR_HIGH: mapper.chr_bank_high = mapper.shift_value;
      SEL_PRG: begin
        mapper.prg_bank     = mapper.shift_value[3:0];
        mapper.save_ram_off = mapper.shift_value[4];
      end
      default: ;
    endcase
  endfunction

  // Works out the result of one bus event and advances the mapper state.
  function automatic sbsm_result_t decode_access(sbsm_op_e op, logic [15:0] a, logic [7:0] d);
    sbsm_result_t r;
    logic [13:0]  v;
    r.target         = TGT_NONE;
    r.mapped_address = '0;
    r.write_strobe   = 1'b0;
    v = a[13:0];
    case (op)
      OP_CPU_READ: begin
        if (a[15:13] == SAVE_RAM_WINDOW) begin
          if (save_ram_disabled()) r.target = TGT_OPEN;
          else if (mapper.save_ram_off) r.target = TGT_ZERO;
          else begin
            r.target         = TGT_SRAM;
            r.mapped_address = save_ram_offset(a);
          end
        end else if (a[15]) begin
          r.target         = TGT_PROM;
          r.mapped_address = prog_rom_offset(a);
        end else begin
          r.target = TGT_OPEN;
        end
      end
      OP_CPU_WRITE: begin
        if (a[15:13] == SAVE_RAM_WINDOW) begin
          if (!save_ram_disabled() && !mapper.save_ram_off) begin
            r.target         = TGT_SRAM;
            r.mapped_address = save_ram_offset(a);
            r.write_strobe   = 1'b1;
          end
        end else if (a[15]) begin
          load_serial_bit(a, d);
        end
      end
      OP_VIDEO_READ: begin
        if (v[13]) begin
          r.target         = TGT_NTBL;
          r.mapped_address = nametable_offset(v);
        end else if (board.chr_rom_present) begin
          r.target         = TGT_CROM;
          r.mapped_address = pattern_offset(v);
        end else if (board.chr_ram_present) begin
          r.target         = TGT_CRAM;
          r.mapped_address = pattern_offset(v);
        end else begin
          r.target = TGT_ZERO;
        end
      end
      OP_VIDEO_WRITE: begin
        if (v[13]) begin
          r.target         = TGT_NTBL;
          r.mapped_address = nametable_offset(v);
          r.write_strobe   = 1'b1;
        end else if (board.chr_ram_present) begin
          r.target         = TGT_CRAM;
          r.mapped_address = pattern_offset(v);
          r.write_strobe   = 1'b1;
        end
      end
      OP_TICK: begin
        if (mapper.write_holdoff != 2'd0) mapper.write_holdoff = mapper.write_holdoff - 2'd1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Results are retired before the word accepted at the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    sbsm_result_t seen;
    sbsm_result_t want;
    if (!rst_ni) begin
      mapper = STATE_RESET;
      board.board_variant   = 3'd0;
      board.chr_rom_present = 1'b1;
      board.chr_ram_present = 1'b0;
      expected_maps.delete();
      mismatch_total = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        seen.target         = sbsm_target_e'(m_tuser_i[2:0]);
        seen.write_strobe   = m_tuser_i[3];
        seen.mapped_address = m_tdata_i[18:0];
        if (expected_maps.size() == 0) begin
          $display("%0t: result word with none expected: target %0d address %h strobe %b",
                   $time, seen.target, seen.mapped_address, seen.write_strobe);
          mismatch_total++;
        end else begin
          want = expected_maps.pop_front();
          if (seen.target != want.target) begin
            $display("%0t: target expected %0d, got %0d", $time, want.target, seen.target);
            mismatch_total++;
          end
          if (seen.mapped_address != want.mapped_address) begin
            $display("%0t: mapped_address expected %h, got %h",
                     $time, want.mapped_address, seen.mapped_address);
            mismatch_total++;
          end
          if (seen.write_strobe != want.write_strobe) begin
            $display("%0t: write_strobe expected %b, got %b",
                     $time, want.write_strobe, seen.write_strobe);
            mismatch_total++;
          end
        end
      end

      // Board settings follow the register writes on the configuration port.
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (sbsm_reg_e'(paddr_i[3:2]))
          REG_BOARD_VARIANT: board.board_variant   = pwdata_i[2:0];
          REG_CHR_ROM:       board.chr_rom_present = pwdata_i[0];
          REG_CHR_RAM:       board.chr_ram_present = pwdata_i[0];
          default: ;
        endcase
      end

      if (s_tvalid_i && s_tready_i)
        expected_maps.push_back(decode_access(sbsm_op_e'(s_tuser_i), s_tdata_i[15:0],
                                              s_tdata_i[23:16]));

      mismatches_o <= mismatch_total;
      pending_o    <= expected_maps.size();
    end
  end

endmodule

@@ tb/serial_bank_switch_mapper_tb.sv @@
// Testbench top for the serial bank switch mapper: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module serial_bank_switch_mapper_tb;
  import sbsm_pkg::*;

  localparam int NUM_PHASES       = 7;
  localparam int ITEMS_PER_PHASE  = 186;
  localparam int QUIET_LIMIT      = 2000;
  localparam int LONG_HOLD_AT     = 400;
  localparam int LONG_HOLD_CYCLES = 150;

  // Board settings per phase, {board_variant, chr_rom_present, chr_ram_present};
  // phase 0 is the last entry and repeats the reset values.
  localparam logic [NUM_PHASES-1:0][4:0] PHASE_CFG = {
    {3'd0, 1'b0, 1'b1},
    {3'd4, 1'b1, 1'b1},
    {3'd3, 1'b1, 1'b0},
    {3'd2, 1'b0, 1'b0},
    {3'd1, 1'b1, 1'b1},
    {3'd4, 1'b0, 1'b1},
    {3'd0, 1'b1, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [15:0] address, [23:16] write_data
  logic [2:0]  s_axis_tuser = '0;   // [2:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [18:0] mapped_address, [23:19] zero
  logic [3:0]  m_axis_tuser;        // [2:0] target, [3] write_strobe
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int unsigned mismatches;
  int unsigned pending;
  int          words_sent = 0;
  bit          sender_steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  serial_bank_switch_mapper i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  sbsm_access_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Offers one bus event word after a random gap and waits for it to be taken.
  task automatic send_event(sbsm_op_e op, logic [15:0] addr, logic [7:0] data);
    int gap;
    if (words_sent % 50 == 0) sender_steady = ($urandom_range(0, 3) == 0);
    gap = sender_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {data, addr};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
  endtask

  // Setup cycle, then access cycle; the register takes the value as the access cycle ends.
  task automatic write_register(sbsm_reg_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drains every outstanding result before the board settings change.
  task automatic apply_board(logic [4:0] setting);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    write_register(REG_BOARD_VARIANT, {29'd0, setting[4:2]});
    write_register(REG_CHR_ROM, {31'd0, setting[1]});
    write_register(REG_CHR_RAM, {31'd0, setting[0]});
  endtask

  // Random access; a quiet one never touches the serial register or the holdoff.
  task automatic send_random_access(bit quiet);
    sbsm_op_e    op;
    logic [15:0] a;
    op = sbsm_op_e'($urandom_range(OP_CPU_READ, quiet ? OP_VIDEO_WRITE : OP_TICK));
    a  = 16'($urandom_range(0, 16'hffff));
    if (op == OP_CPU_READ || op == OP_CPU_WRITE) begin
      case ($urandom_range(0, 3))
        0: a = {3'b011, a[12:0]};
        1: a[15] = 1'b0;
        2: a[15] = 1'b1;
        default: ;
      endcase
      if (quiet && op == OP_CPU_WRITE) a[15] = 1'b0;
    end
    send_event(op, a, 8'($urandom_range(0, 255)));
  endtask

  // Five serial bits into one register, with a holdoff and some traffic after each write.
  // Now and then a reset write aborts the load, or a tick is missed so the next bit is lost.
  task automatic send_serial_load();
    logic [1:0] sel;
    logic [4:0] value;
    logic [7:0] d;
    int         ticks;
    sel   = 2'($urandom_range(0, 3));
    value = 5'($urandom_range(0, 31));
    for (int i = 0; i < SHIFT_BITS; i++) begin
      d    = 8'($urandom_range(0, 255));
      d[7] = ($urandom_range(0, 19) == 0);
      d[0] = value[i];
      send_event(OP_CPU_WRITE, {1'b1, sel, 13'($urandom_range(0, 8191))}, d);
      repeat ($urandom_range(0, 2)) send_random_access(1'b1);
      ticks = ($urandom_range(0, 9) == 0) ? 1 : int'(HOLDOFF_TICKS);
      repeat (ticks) send_event(OP_TICK, 16'($urandom_range(0, 16'hffff)),
                                8'($urandom_range(0, 255)));
    end
  endtask

  // Result side: random stall per word, one long hold that backs up the input.
  initial begin : result_sink
    int taken;
    int stall;
    bit steady;
    taken  = 0;
    steady = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      stall = steady ? 0 : $urandom_range(0, 7);
      if (taken == LONG_HOLD_AT) stall = LONG_HOLD_CYCLES;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      taken++;
    end
  end

  // Ends the run when neither channel nor the register port has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || psel || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("serial_bank_switch_mapper_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int phase_end;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings: field extremes and the plain decode paths.
    send_event(OP_CPU_READ, 16'h0000, 8'h00);
    send_event(OP_CPU_READ, 16'hffff, 8'hff);
    send_event(OP_CPU_READ, 16'h6000, 8'h00);
    send_event(OP_CPU_READ, 16'h7fff, 8'h00);
    send_event(OP_CPU_READ, 16'h4000, 8'h00);
    send_event(OP_CPU_WRITE, 16'h5fff, 8'hff);
    send_event(OP_CPU_WRITE, 16'h6000, 8'h00);
    send_event(OP_CPU_WRITE, 16'h7fff, 8'hff);
    send_event(OP_VIDEO_READ, 16'h0000, 8'h00);
    send_event(OP_VIDEO_READ, 16'h1fff, 8'h00);
    send_event(OP_VIDEO_READ, 16'h3fff, 8'h00);
    send_event(OP_VIDEO_READ, 16'hffff, 8'h00);
    send_event(OP_VIDEO_WRITE, 16'h0000, 8'h5a);
    send_event(OP_VIDEO_WRITE, 16'h2000, 8'ha5);
    send_event(OP_TICK, 16'h0000, 8'h00);
    // Reset write, a write swallowed by the holdoff, then the holdoff runs out.
    send_event(OP_CPU_WRITE, 16'h8000, 8'h80);
    send_event(OP_CPU_WRITE, 16'h8000, 8'h01);
    send_event(OP_TICK, 16'h0000, 8'h00);
    send_event(OP_TICK, 16'hffff, 8'hff);
    send_event(OP_CPU_WRITE, 16'hffff, 8'h7f);
    send_event(OP_TICK, 16'h0000, 8'h00);

    // Random part, one board setting per phase.
    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_board(PHASE_CFG[p]);
      phase_end = words_sent + ITEMS_PER_PHASE;
      while (words_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: send_serial_load();
          9: send_event(OP_CPU_WRITE, 16'h8000 | 16'($urandom_range(0, 16'h7fff)),
                        8'($urandom_range(0, 255)));
          default: send_random_access(1'b0);
        endcase
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("serial_bank_switch_mapper_tb: done, clean");
    else
      $display("serial_bank_switch_mapper_tb: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
src/sbsm_pkg.sv
src/sbsm_decode.sv
src/serial_bank_switch_mapper.sv
tb/sbsm_access_checker.sv
tb/serial_bank_switch_mapper_tb.sv
